@@ rtl/core/thread_scheduler_with_mutexes_macros.svh @@
// Assertion helpers for the thread scheduler.
`ifndef THREAD_SCHEDULER_WITH_MUTEXES_MACROS_SVH
`define THREAD_SCHEDULER_WITH_MUTEXES_MACROS_SVH

// Property checked on every edge outside of reset
`define TSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Property checked on every edge, reset included
`define TSM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

@@ rtl/core/tsm_pkg.sv @@
`default_nettype none

package tsm_pkg;

    // fixed sizes
    localparam int THREAD_SLOTS = 8;
    localparam int MUTEX_SLOTS  = 8;
    localparam logic [3:0] NO_OWNER = 4'd8;

    // thread status codes
    localparam logic [1:0] TS_WAITING  = 2'd0;
    localparam logic [1:0] TS_ACTIVE   = 2'd1;
    localparam logic [1:0] TS_SLEEPING = 2'd2;
    localparam logic [1:0] TS_BLOCKED  = 2'd3;

    // function codes of an input word
    localparam logic [2:0] FN_START   = 3'd0;
    localparam logic [2:0] FN_TICK    = 3'd1;
    localparam logic [2:0] FN_YIELD   = 3'd2;
    localparam logic [2:0] FN_ACQUIRE = 3'd3;
    localparam logic [2:0] FN_RELEASE = 3'd4;

    // mutex result codes
    localparam logic [2:0] RES_NONE      = 3'd0;
    localparam logic [2:0] RES_ACQUIRED  = 3'd1;
    localparam logic [2:0] RES_BLOCKED   = 3'd2;
    localparam logic [2:0] RES_REPEAT    = 3'd3;
    localparam logic [2:0] RES_HANDED_ON = 3'd4;
    localparam logic [2:0] RES_FREED     = 3'd5;
    localparam logic [2:0] RES_NOT_OWNER = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_THREAD_COUNT = 3'd0;
    localparam logic [2:0] CFG_IDLE_THREAD  = 3'd1;
    localparam logic [2:0] CFG_MUTEX_COUNT  = 3'd2;
    localparam logic [2:0] CFG_TIMESLICE    = 3'd3;
    localparam logic [2:0] CFG_SLEEP        = 3'd4;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] mutex_id;
    } tsm_in_t;

    typedef struct packed {
        logic [2:0] running_thread;
        logic       switch_request;
        logic [2:0] mutex_result;
        logic [3:0] new_owner;
    } tsm_out_t;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START,
        CMD_TICK_STEP,
        CMD_TICK_CHECK,
        CMD_YIELD,
        CMD_ACQUIRE,
        CMD_REL_STEP,
        CMD_REL_APPLY,
        CMD_SCHED_INIT,
        CMD_SCHED_STEP
    } tsm_cmd_e;

    typedef struct packed {
        tsm_cmd_e cmd;
        logic     load_result;
    } tsm_ctrl_t;

    typedef struct packed {
        logic [2:0] func;
        logic       walk_last;
        logic       tick_expire;
        logic       acq_block;
        logic       sched_multi;
        logic       sched_end;
        logic       out_free;
    } tsm_stat_t;

    // a mod n for a <= 8, 2 <= n <= 8
    function automatic logic [2:0] mod_small(input logic [3:0] a, input logic [3:0] n);
        logic [3:0] r;
        r = a;
        for (int k = 0; k < 4; k++) begin
            if (r >= n) begin
                r = r - n;
            end
        end
        return r[2:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tsm_ctrl.sv @@
`default_nettype none

module tsm_ctrl import tsm_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire tsm_stat_t stat,
    output tsm_ctrl_t      ctrl
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DECODE    = 9'b000000010,
        ST_TICK      = 9'b000000100,
        ST_TICK_CHK  = 9'b000001000,
        ST_REL       = 9'b000010000,
        ST_REL_APPLY = 9'b000100000,
        ST_SCHED_INI = 9'b001000000,
        ST_SCHED     = 9'b010000000,
        ST_DONE      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // next state and command
    always_comb begin
        state_next       = state_reg;
        ctrl.cmd         = CMD_NONE;
        ctrl.load_result = 1'b0;
        s_ready          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.cmd   = CMD_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.func)
                    FN_START: begin
                        ctrl.cmd   = CMD_START;
                        state_next = ST_DONE;
                    end
                    FN_TICK:    state_next = ST_TICK;
                    FN_YIELD: begin
                        ctrl.cmd   = CMD_YIELD;
                        state_next = ST_SCHED_INI;
                    end
                    FN_ACQUIRE: begin
                        ctrl.cmd   = CMD_ACQUIRE;
                        state_next = stat.acq_block ? ST_SCHED_INI : ST_DONE;
                    end
                    FN_RELEASE: state_next = ST_REL;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_TICK: begin
                ctrl.cmd = CMD_TICK_STEP;
                if (stat.walk_last) begin
                    state_next = ST_TICK_CHK;
                end
            end
            ST_TICK_CHK: begin
                ctrl.cmd   = CMD_TICK_CHECK;
                state_next = stat.tick_expire ? ST_SCHED_INI : ST_DONE;
            end
            ST_REL: begin
                ctrl.cmd = CMD_REL_STEP;
                if (stat.walk_last) begin
                    state_next = ST_REL_APPLY;
                end
            end
            ST_REL_APPLY: begin
                ctrl.cmd   = CMD_REL_APPLY;
                state_next = ST_DONE;
            end
            ST_SCHED_INI: begin
                ctrl.cmd   = CMD_SCHED_INIT;
                state_next = stat.sched_multi ? ST_SCHED : ST_DONE;
            end
            ST_SCHED: begin
                ctrl.cmd = CMD_SCHED_STEP;
                if (stat.sched_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    ctrl.load_result = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tsm_datapath.sv @@
`default_nettype none

module tsm_datapath import tsm_pkg::*; #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire tsm_in_t     s_data,
    input  wire tsm_ctrl_t   ctrl,
    input  wire logic        out_free,
    output tsm_stat_t        stat,
    output tsm_out_t         result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int TW = TIMER_WIDTH;
    localparam logic [TW-1:0] TMAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic [TW-1:0] TMIN = {1'b1, {(TW-1){1'b0}}};

    typedef logic signed [TW-1:0] timer_t;

    // configuration
    logic [3:0]  thread_count_reg, thread_count_next;
    logic [2:0]  idle_thread_reg, idle_thread_next;
    logic [3:0]  mutex_count_reg, mutex_count_next;
    logic [63:0] slice_tab_reg, slice_tab_next;
    logic [63:0] sleep_tab_reg, sleep_tab_next;

    // thread and mutex state
    logic [1:0] status_reg [THREAD_SLOTS];
    logic [1:0] status_next [THREAD_SLOTS];
    timer_t     timer_reg [THREAD_SLOTS];
    timer_t     timer_next [THREAD_SLOTS];
    logic [3:0] wait_for_reg [THREAD_SLOTS];
    logic [3:0] wait_for_next [THREAD_SLOTS];
    logic       mfree_reg [MUTEX_SLOTS];
    logic       mfree_next [MUTEX_SLOTS];
    logic [3:0] holder_reg [MUTEX_SLOTS];
    logic [3:0] holder_next [MUTEX_SLOTS];
    logic [2:0] cur_reg, cur_next;
    logic       wake_reg, wake_next;
    logic       from_idle_reg, from_idle_next;

    // per-word work registers
    logic [2:0] func_reg, func_next;
    logic [2:0] mid_reg, mid_next;
    logic [3:0] idx_reg, idx_next;
    logic [2:0] cand_reg, cand_next;
    logic [2:0] best_reg, best_next;
    timer_t     best_tmr_reg, best_tmr_next;
    logic       found_reg, found_next;
    logic       sw_reg, sw_next;
    logic [2:0] res_reg, res_next;
    logic [3:0] owner_reg, owner_next;

    logic [3:0] n_thr;
    logic [3:0] n_mtx;
    logic [2:0] walk_i;
    logic       mutex_ok;
    logic [3:0] cur_ext;
    timer_t     dec_val;
    logic [7:0] sleep_cur;

    // saturating load of an unsigned table byte
    function automatic timer_t sat_load(input logic [7:0] b);
        logic [32:0] wide;
        logic [32:0] lim;
        wide = {25'd0, b};
        lim  = {{(33-TW){1'b0}}, TMAX};
        if (wide > lim) begin
            return TMAX;
        end
        return wide[TW-1:0];
    endfunction

    function automatic timer_t sat_dec(input timer_t t);
        if (t == TMIN) begin
            return t;
        end
        return t - timer_t'(1);
    endfunction

    function automatic logic le_zero(input timer_t t);
        return t[TW-1] || (t == '0);
    endfunction

    assign n_thr     = (thread_count_reg > 4'd8) ? 4'd8 : thread_count_reg;
    assign n_mtx     = (mutex_count_reg > 4'd8) ? 4'd8 : mutex_count_reg;
    assign walk_i    = idx_reg[2:0];
    assign mutex_ok  = {1'b0, mid_reg} < n_mtx;
    assign cur_ext   = {1'b0, cur_reg};
    assign dec_val   = (status_reg[walk_i] != TS_WAITING) ? sat_dec(timer_reg[walk_i])
                                                          : timer_reg[walk_i];
    assign sleep_cur = sleep_tab_reg[{cur_reg, 3'b000} +: 8];

    // status toward the controller
    assign stat.func        = func_reg;
    assign stat.walk_last   = ({1'b0, idx_reg} + 5'd1) >= {1'b0, n_thr};
    assign stat.tick_expire = (le_zero(timer_reg[cur_reg])
                               && (status_reg[cur_reg] != TS_BLOCKED)) || wake_reg;
    assign stat.acq_block   = mutex_ok && !mfree_reg[mid_reg]
                              && (holder_reg[mid_reg] != cur_ext);
    assign stat.sched_multi = n_thr > 4'd1;
    assign stat.sched_end   = (status_reg[cand_reg] == TS_WAITING)
                              || (({1'b0, idx_reg} + 5'd1) >= {1'b0, n_thr});
    assign stat.out_free    = out_free;

    assign result.running_thread = cur_reg;
    assign result.switch_request = sw_reg;
    assign result.mutex_result   = res_reg;
    assign result.new_owner      = owner_reg;

    // datapath operations
    always_comb begin
        thread_count_next = thread_count_reg;
        idle_thread_next  = idle_thread_reg;
        mutex_count_next  = mutex_count_reg;
        slice_tab_next    = slice_tab_reg;
        sleep_tab_next    = sleep_tab_reg;
        status_next       = status_reg;
        timer_next        = timer_reg;
        wait_for_next     = wait_for_reg;
        mfree_next        = mfree_reg;
        holder_next       = holder_reg;
        cur_next          = cur_reg;
        wake_next         = wake_reg;
        from_idle_next    = from_idle_reg;
        func_next         = func_reg;
        mid_next          = mid_reg;
        idx_next          = idx_reg;
        cand_next         = cand_reg;
        best_next         = best_reg;
        best_tmr_next     = best_tmr_reg;
        found_next        = found_reg;
        sw_next           = sw_reg;
        res_next          = res_reg;
        owner_next        = owner_reg;

        // configuration writes, to be made only while idle; the block itself does not enforce it
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_THREAD_COUNT: thread_count_next = cfg_data[3:0];
                CFG_IDLE_THREAD:  idle_thread_next  = cfg_data[2:0];
                CFG_MUTEX_COUNT: begin
                    mutex_count_next = cfg_data[3:0];
                    for (int k = 0; k < MUTEX_SLOTS; k++) begin
                        mfree_next[k]  = 1'b1;
                        holder_next[k] = NO_OWNER;
                    end
                end
                CFG_TIMESLICE: slice_tab_next = cfg_data;
                CFG_SLEEP:     sleep_tab_next = cfg_data;
                default: ;
            endcase
        end

        unique case (ctrl.cmd)
            CMD_LOAD: begin
                func_next      = s_data.func;
                mid_next       = s_data.mutex_id;
                idx_next       = '0;
                sw_next        = 1'b0;
                res_next       = RES_NONE;
                owner_next     = NO_OWNER;
                found_next     = 1'b0;
                from_idle_next = 1'b0;
            end
            CMD_START: begin
                cur_next = '0;
                if (n_thr != 4'd0) begin
                    status_next[0] = TS_ACTIVE;
                    sw_next        = 1'b1;
                end
            end
            CMD_TICK_STEP: begin
                if (idx_reg < n_thr) begin
                    if ((status_reg[walk_i] == TS_SLEEPING) && le_zero(dec_val)) begin
                        status_next[walk_i] = TS_WAITING;
                        timer_next[walk_i]  = sat_load(slice_tab_reg[{walk_i, 3'b000} +: 8]);
                        if (cur_reg == idle_thread_reg) begin
                            wake_next = 1'b1;
                        end
                    end else begin
                        timer_next[walk_i] = dec_val;
                    end
                end
                idx_next = idx_reg + 4'd1;
            end
            CMD_TICK_CHECK: begin
                if (stat.tick_expire) begin
                    // current thread gives up the processor; sleeps or gets its slice reloaded
                    if (sleep_cur != 8'd0) begin
                        status_next[cur_reg] = TS_SLEEPING;
                        timer_next[cur_reg]  = sat_load(sleep_cur);
                    end else begin
                        status_next[cur_reg] = TS_WAITING;
                        timer_next[cur_reg]  =
                            sat_load(slice_tab_reg[{cur_reg, 3'b000} +: 8]);
                    end
                    from_idle_next = wake_reg;
                    wake_next      = 1'b0;
                    sw_next        = 1'b1;
                end
            end
            CMD_YIELD: begin
                if (sleep_cur != 8'd0) begin
                    status_next[cur_reg] = TS_SLEEPING;
                    timer_next[cur_reg]  = sat_load(sleep_cur);
                end else begin
                    status_next[cur_reg] = TS_WAITING;
                end
                sw_next = 1'b1;
            end
            CMD_ACQUIRE: begin
                if (mutex_ok) begin
                    if (mfree_reg[mid_reg]) begin
                        mfree_next[mid_reg]  = 1'b0;
                        holder_next[mid_reg] = cur_ext;
                        res_next             = RES_ACQUIRED;
                        owner_next           = cur_ext;
                    end else if (holder_reg[mid_reg] != cur_ext) begin
                        status_next[cur_reg]   = TS_BLOCKED;
                        timer_next[cur_reg]    = '0;
                        wait_for_next[cur_reg] = {1'b0, mid_reg};
                        res_next               = RES_BLOCKED;
                        sw_next                = 1'b1;
                        owner_next             = holder_reg[mid_reg];
                    end else begin
                        res_next   = RES_REPEAT;
                        owner_next = holder_reg[mid_reg];
                    end
                end
            end
            CMD_REL_STEP: begin
                // longest waiter: smallest timer, lowest index on ties
                if (idx_reg < n_thr) begin
                    if ((status_reg[walk_i] == TS_BLOCKED)
                        && (wait_for_reg[walk_i] == {1'b0, mid_reg})) begin
                        if (!found_reg || (timer_reg[walk_i] < best_tmr_reg)) begin
                            best_next     = walk_i;
                            best_tmr_next = timer_reg[walk_i];
                        end
                        found_next = 1'b1;
                    end
                end
                idx_next = idx_reg + 4'd1;
            end
            CMD_REL_APPLY: begin
                if (mutex_ok) begin
                    if (holder_reg[mid_reg] == cur_ext) begin
                        if (found_reg) begin
                            status_next[best_reg]   = TS_WAITING;
                            timer_next[best_reg]    =
                                sat_load(slice_tab_reg[{best_reg, 3'b000} +: 8]);
                            wait_for_next[best_reg] = NO_OWNER;
                            mfree_next[mid_reg]     = 1'b0;
                            holder_next[mid_reg]    = {1'b0, best_reg};
                            res_next                = RES_HANDED_ON;
                            owner_next              = {1'b0, best_reg};
                        end else begin
                            mfree_next[mid_reg]  = 1'b1;
                            holder_next[mid_reg] = NO_OWNER;
                            res_next             = RES_FREED;
                            owner_next           = NO_OWNER;
                        end
                    end else begin
                        res_next   = RES_NOT_OWNER;
                        owner_next = holder_reg[mid_reg];
                    end
                end
            end
            CMD_SCHED_INIT: begin
                idx_next = '0;
                if (n_thr > 4'd1) begin
                    if (from_idle_reg || (cur_reg == idle_thread_reg)) begin
                        cand_next = mod_small({1'b0, idle_thread_reg}, n_thr);
                    end else begin
                        cand_next = mod_small(cur_ext + 4'd1, n_thr);
                    end
                end else begin
                    status_next[cur_reg] = TS_ACTIVE;
                end
            end
            CMD_SCHED_STEP: begin
                if (status_reg[cand_reg] == TS_WAITING) begin
                    cur_next              = cand_reg;
                    status_next[cand_reg] = TS_ACTIVE;
                end else if (({1'b0, idx_reg} + 5'd1) >= {1'b0, n_thr}) begin
                    // nobody waits: fall back to the idle thread
                    cur_next                     = idle_thread_reg;
                    status_next[idle_thread_reg] = TS_ACTIVE;
                end else begin
                    cand_next = (({1'b0, cand_reg} + 4'd1) == n_thr) ? 3'd0
                                                                     : cand_reg + 3'd1;
                    idx_next  = idx_reg + 4'd1;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thread_count_reg <= 4'd1;
            idle_thread_reg  <= '0;
            mutex_count_reg  <= '0;
            slice_tab_reg    <= '0;
            sleep_tab_reg    <= '0;
            for (int k = 0; k < THREAD_SLOTS; k++) begin
                status_reg[k]   <= TS_WAITING;
                timer_reg[k]    <= '0;
                wait_for_reg[k] <= NO_OWNER;
            end
            for (int k = 0; k < MUTEX_SLOTS; k++) begin
                mfree_reg[k]  <= 1'b1;
                holder_reg[k] <= NO_OWNER;
            end
            cur_reg       <= '0;
            wake_reg      <= 1'b0;
            from_idle_reg <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
        end else begin
            thread_count_reg <= thread_count_next;
            idle_thread_reg  <= idle_thread_next;
            mutex_count_reg  <= mutex_count_next;
            slice_tab_reg    <= slice_tab_next;
            sleep_tab_reg    <= sleep_tab_next;
            status_reg       <= status_next;
            timer_reg        <= timer_next;
            wait_for_reg     <= wait_for_next;
            mfree_reg        <= mfree_next;
            holder_reg       <= holder_next;
            cur_reg          <= cur_next;
            wake_reg         <= wake_next;
            from_idle_reg    <= from_idle_next;
            idx_reg          <= idx_next;
            found_reg        <= found_next;
        end
    end

    // per-word payload
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        mid_reg      <= mid_next;
        cand_reg     <= cand_next;
        best_reg     <= best_next;
        best_tmr_reg <= best_tmr_next;
        sw_reg       <= sw_next;
        res_reg      <= res_next;
        owner_reg    <= owner_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/thread_scheduler_with_mutexes.sv @@
// Flow: start, acquire without blocking and unknown words go straight from decode to the result
//   register; tick and release first walk the n configured threads, one per cycle, and a
//   reschedule adds a search over up to n candidate threads.
// Throughput: one word at a time; the next word is taken as soon as the result is registered.
// Reset: aresetn synchronous, active low; all threads waiting, mutexes free, thread 0 current.
`default_nettype none

module thread_scheduler_with_mutexes import tsm_pkg::*; #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire tsm_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output tsm_out_t         m_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    tsm_ctrl_t ctrl;
    tsm_stat_t stat;
    tsm_out_t  result;
    logic      out_free;

    logic     out_valid_reg, out_valid_next;
    tsm_out_t out_data_reg, out_data_next;

    tsm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    tsm_datapath #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .ctrl      (ctrl),
        .out_free  (out_free),
        .stat      (stat),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // output register
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (ctrl.load_result) begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/tsm_checker.sv @@
`default_nettype none
`include "thread_scheduler_with_mutexes_macros.svh"

module tsm_checker import tsm_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire tsm_in_t  s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire tsm_out_t m_data
);

    // a held result word stays put
    `TSM_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result word changed while stalled")

    // one word in flight: ready drops after an accept
    `TSM_ASSERT(a_one_word, s_valid && s_ready |=> !s_ready, "second word taken while busy")

    // no mutex outcome means no owner reported
    `TSM_ASSERT(a_none_owner, m_valid && (m_data.mutex_result == RES_NONE) |-> (m_data.new_owner == NO_OWNER), "owner reported without mutex outcome")

    // only blocking mutex outcomes request a switch
    `TSM_ASSERT(a_mutex_sw, m_valid && (m_data.mutex_result != RES_NONE) && (m_data.mutex_result != RES_BLOCKED) |-> !m_data.switch_request, "switch on non-blocking mutex word")

    // nothing leaves right after reset
    `TSM_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind thread_scheduler_with_mutexes tsm_checker u_tsm_checker (.*);

`default_nettype wire
